### hw/rtl/cylindrical_to_cartesian_with_derivs_macros.svh
// Assertion macros for the cylindrical to Cartesian block
`ifndef CYLINDRICAL_TO_CARTESIAN_WITH_DERIVS_MACROS_SVH
`define CYLINDRICAL_TO_CARTESIAN_WITH_DERIVS_MACROS_SVH

// hold post in the same cycle as pre
`define C2C_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// hold post in the cycle after pre
`define C2C_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

// hold post in the cycle after reset is seen asserted
`define C2C_ASSERT_IN_RESET(lbl, clk, rst_n, post, msg) \
  lbl: assert property (@(posedge clk) !(rst_n) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/c2c_pkg.sv
// Types, constants and helper functions for the cylindrical to Cartesian block
package c2c_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned CordicStages = 24;
  localparam int unsigned SatWidth     = (DataWidth > 32) ? 32 : DataWidth;

  localparam int unsigned CordicXw = 34;
  localparam int unsigned CordicZw = 33;

  localparam logic signed [CordicXw-1:0] CordicX0 = 34'sd652032874;
  localparam logic signed [31:0]         TrigOne  = 32'sd1073741824;
  localparam logic signed [63:0]         RoundHalf = 64'sd536870912;

  localparam logic signed [CordicZw-1:0] AtanTab [32] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10680862,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81,
    33'sd41,        33'sd20,        33'sd10,        33'sd5,
    33'sd3,         33'sd1,         33'sd1,         33'sd0
  };

  typedef enum logic [1:0] {
    KindX = 2'd0,
    KindY = 2'd1,
    KindZ = 2'd2
  } c2c_kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] rho;
    logic signed [31:0] height;
  } c2c_tag_t;

  function automatic logic signed [31:0] sat_data(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SatWidth - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_trig(input logic signed [CordicXw-1:0] v);
    if (v > CordicXw'(TrigOne)) begin
      return TrigOne;
    end else if (v < -CordicXw'(TrigOne)) begin
      return -TrigOne;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + RoundHalf) >>> 30;
    return sat_data(t);
  endfunction

endpackage

### hw/rtl/c2c_cordic.sv
// Pipelined rotation CORDIC with quadrant fold for a binary angle
module c2c_cordic #(
  parameter int unsigned CORDIC_STAGES = c2c_pkg::CordicStages
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [31:0]                           phi_i,
  input  c2c_pkg::c2c_tag_t                     tag_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [c2c_pkg::CordicXw-1:0]   x_o,
  output logic signed [c2c_pkg::CordicXw-1:0]   y_o,
  output logic [1:0]                            quad_o,
  output c2c_pkg::c2c_tag_t                     tag_o
);
  import c2c_pkg::*;

  logic [0:CORDIC_STAGES] vld_q, vld_d, en;

  logic signed [CordicXw-1:0] x_q [0:CORDIC_STAGES];
  logic signed [CordicXw-1:0] y_q [0:CORDIC_STAGES];
  logic signed [CordicZw-1:0] z_q [0:CORDIC_STAGES];
  logic [1:0]                 quad_q [0:CORDIC_STAGES];
  c2c_tag_t                   tag_q [0:CORDIC_STAGES];

  logic signed [CordicXw-1:0] x_d [1:CORDIC_STAGES];
  logic signed [CordicXw-1:0] y_d [1:CORDIC_STAGES];
  logic signed [CordicZw-1:0] z_d [1:CORDIC_STAGES];

  logic [31:0]          phi_rnd;
  logic [1:0]           quad_in;
  logic [31:0]          resid;
  logic signed [CordicZw-1:0] z_in;

  assign phi_rnd = phi_i + 32'h2000_0000;
  assign quad_in = phi_rnd[31:30];
  assign resid   = phi_i - {quad_in, 30'd0};
  assign z_in    = {resid[31], resid};

  always_comb begin
    en[CORDIC_STAGES] = !vld_q[CORDIC_STAGES] || out_ready_i;
    for (int k = CORDIC_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_comb begin
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      if (!z_q[k-1][CordicZw-1]) begin
        x_d[k] = x_q[k-1] - (y_q[k-1] >>> (k - 1));
        y_d[k] = y_q[k-1] + (x_q[k-1] >>> (k - 1));
        z_d[k] = z_q[k-1] - AtanTab[5'(k - 1)];
      end else begin
        x_d[k] = x_q[k-1] + (y_q[k-1] >>> (k - 1));
        y_d[k] = y_q[k-1] - (x_q[k-1] >>> (k - 1));
        z_d[k] = z_q[k-1] + AtanTab[5'(k - 1)];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]    <= CordicX0;
      y_q[0]    <= '0;
      z_q[0]    <= z_in;
      quad_q[0] <= quad_in;
      tag_q[0]  <= tag_i;
    end
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      if (en[k]) begin
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
        z_q[k]    <= z_d[k];
        quad_q[k] <= quad_q[k-1];
        tag_q[k]  <= tag_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[CORDIC_STAGES];
  assign x_o         = x_q[CORDIC_STAGES];
  assign y_o         = y_q[CORDIC_STAGES];
  assign quad_o      = quad_q[CORDIC_STAGES];
  assign tag_o       = tag_q[CORDIC_STAGES];

endmodule

### hw/rtl/cylindrical_to_cartesian_with_derivs.sv
// Top level: cylindrical to Cartesian component with first and second derivatives
//
// channel   dir  tdata fields (low bit up)                                tuser
// s_axis    in   rho[31:0] phi[63:32] height[95:64]                       kind[1:0]
// m_axis    out  coord_value[31:0] d_by_rho[63:32] d_by_phi[95:64]        -
//                d_by_height[96] d2_phi_phi[128:97] d2_rho_phi[160:129]
//
// One request per cycle when not stalled; each request taken passes through
// CORDIC_STAGES + 4 register stages before its result is valid.
// Depth is set by the CORDIC: an input load stage, one stage per iteration,
// then trig select, multiply, and round/saturate stages.
// Each stage holds while full and blocked downstream; bubbles close up.
// Reset clears the valid bits only; no clearing pass.
module cylindrical_to_cartesian_with_derivs #(
  parameter int unsigned CORDIC_STAGES = c2c_pkg::CordicStages
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [95:0]   s_axis_tdata_i,   // rho, phi, height
  input  logic [1:0]    s_axis_tuser_i,   // kind
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [167:0]  m_axis_tdata_o    // coord_value, d_by_rho, d_by_phi, d_by_height,
                                          // d2_phi_phi, d2_rho_phi, zero pad
);
  import c2c_pkg::*;

  c2c_tag_t                   in_tag, cor_tag;
  logic                       cor_valid, cor_ready;
  logic signed [CordicXw-1:0] cor_x, cor_y;
  logic [1:0]                 cor_quad;

  logic [1:3] vld_q, vld_d, en;

  logic signed [CordicXw-1:0] c_raw, s_raw;
  logic signed [31:0]         c_tr, s_tr, nc_tr, ns_tr;
  logic signed [31:0]         a_d, b_d, e_d, dr_d, drp_d;

  logic [1:0]         s1_kind_q;
  logic signed [31:0] s1_rho_q, s1_height_q;
  logic signed [31:0] s1_a_q, s1_b_q, s1_e_q, s1_dr_q, s1_drp_q;

  logic [1:0]         s2_kind_q;
  logic signed [31:0] s2_height_q, s2_dr_q, s2_drp_q;
  logic signed [63:0] s2_pv_q, s2_pdp_q, s2_pdpp_q;
  logic signed [63:0] s2_pv_d, s2_pdp_d, s2_pdpp_d;

  logic signed [31:0] val_d, dp_d, dpp_d, o_dr_d, o_drp_d;
  logic               dh_d;
  logic signed [31:0] val_q, dp_q, dpp_q, o_dr_q, o_drp_q;
  logic               dh_q;

  assign in_tag.kind   = s_axis_tuser_i;
  assign in_tag.rho    = s_axis_tdata_i[31:0];
  assign in_tag.height = s_axis_tdata_i[95:64];

  c2c_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .phi_i      (s_axis_tdata_i[63:32]),
    .tag_i      (in_tag),
    .out_valid_o(cor_valid),
    .out_ready_i(cor_ready),
    .x_o        (cor_x),
    .y_o        (cor_y),
    .quad_o     (cor_quad),
    .tag_o      (cor_tag)
  );

  always_comb begin
    en[3] = !vld_q[3] || m_axis_tready_i;
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
    vld_d[1] = en[1] ? cor_valid : vld_q[1];
    vld_d[2] = en[2] ? vld_q[1]  : vld_q[2];
    vld_d[3] = en[3] ? vld_q[2]  : vld_q[3];
  end

  assign cor_ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    case (cor_quad)
      2'd0: begin
        c_raw = cor_x;
        s_raw = cor_y;
      end
      2'd1: begin
        c_raw = -cor_y;
        s_raw = cor_x;
      end
      2'd2: begin
        c_raw = -cor_x;
        s_raw = -cor_y;
      end
      default: begin
        c_raw = cor_y;
        s_raw = -cor_x;
      end
    endcase
    c_tr  = clamp_trig(c_raw);
    s_tr  = clamp_trig(s_raw);
    nc_tr = -c_tr;
    ns_tr = -s_tr;
    case (cor_tag.kind)
      KindX: begin
        a_d   = c_tr;
        b_d   = ns_tr;
        e_d   = nc_tr;
        dr_d  = c_tr;
        drp_d = ns_tr;
      end
      KindY: begin
        a_d   = s_tr;
        b_d   = c_tr;
        e_d   = ns_tr;
        dr_d  = s_tr;
        drp_d = c_tr;
      end
      default: begin
        a_d   = '0;
        b_d   = '0;
        e_d   = '0;
        dr_d  = '0;
        drp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_kind_q   <= cor_tag.kind;
      s1_rho_q    <= cor_tag.rho;
      s1_height_q <= cor_tag.height;
      s1_a_q      <= a_d;
      s1_b_q      <= b_d;
      s1_e_q      <= e_d;
      s1_dr_q     <= dr_d;
      s1_drp_q    <= drp_d;
    end
  end

  assign s2_pv_d   = s1_rho_q * s1_a_q;
  assign s2_pdp_d  = s1_rho_q * s1_b_q;
  assign s2_pdpp_d = s1_rho_q * s1_e_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_kind_q   <= s1_kind_q;
      s2_height_q <= s1_height_q;
      s2_dr_q     <= s1_dr_q;
      s2_drp_q    <= s1_drp_q;
      s2_pv_q     <= s2_pv_d;
      s2_pdp_q    <= s2_pdp_d;
      s2_pdpp_q   <= s2_pdpp_d;
    end
  end

  always_comb begin
    o_dr_d  = s2_dr_q;
    o_drp_d = s2_drp_q;
    case (s2_kind_q)
      KindX, KindY: begin
        val_d = round_sat(s2_pv_q);
        dp_d  = round_sat(s2_pdp_q);
        dpp_d = round_sat(s2_pdpp_q);
        dh_d  = 1'b0;
      end
      KindZ: begin
        val_d = sat_data(64'(s2_height_q));
        dp_d  = '0;
        dpp_d = '0;
        dh_d  = 1'b1;
      end
      default: begin
        val_d = '0;
        dp_d  = '0;
        dpp_d = '0;
        dh_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      val_q   <= val_d;
      o_dr_q  <= o_dr_d;
      dp_q    <= dp_d;
      dh_q    <= dh_d;
      dpp_q   <= dpp_d;
      o_drp_q <= o_drp_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[3];
  assign m_axis_tdata_o  = {7'd0, o_drp_q, dpp_q, dh_q, dp_q, o_dr_q, val_q};

endmodule

### hw/rtl/c2c_checker.sv
// Port-level checker for the cylindrical to Cartesian block, with its bind
`include "cylindrical_to_cartesian_with_derivs_macros.svh"

module c2c_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [167:0]  m_axis_tdata_o
);
  import c2c_pkg::*;

  logic               z_res;
  logic               z_clear;
  logic signed [31:0] res_dr;
  logic signed [31:0] res_drp;
  logic               dr_ok;
  logic               drp_ok;

  assign z_res   = m_axis_tvalid_o && m_axis_tdata_o[96];
  assign z_clear = (m_axis_tdata_o[95:32] == 64'd0) && (m_axis_tdata_o[160:97] == 64'd0);
  assign res_dr  = m_axis_tdata_o[63:32];
  assign res_drp = m_axis_tdata_o[160:129];
  assign dr_ok   = (res_dr <= TrigOne) && (res_dr >= -TrigOne);
  assign drp_ok  = (res_drp <= TrigOne) && (res_drp >= -TrigOne);

  `C2C_ASSERT_IN_RESET(a_no_result_in_reset, clk_i, rst_ni, !m_axis_tvalid_o, "result in reset")

  `C2C_ASSERT_SAME(a_z_derivs_zero, clk_i, rst_ni, z_res, z_clear, "z result with derivative")

  `C2C_ASSERT_SAME(a_trig_range, clk_i, rst_ni, m_axis_tvalid_o, dr_ok && drp_ok, "trig out of range")

  `C2C_ASSERT_NEXT(a_result_held, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind cylindrical_to_cartesian_with_derivs c2c_checker u_c2c_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
